### rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the scheduler checkers.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DPPS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dpps assertion failed");

// Condition must never be seen outside reset.
`define DPPS_NEVER(lbl, clk, rst, cond) \
   `DPPS_ASSERT(lbl, clk, rst, !(cond))

`endif

### rtl/dpps_pkg.sv
// -----------------------------------------------------------------------------
// Scheduler package
// Sizes, codes, record types and helper functions of the task scheduler.
// -----------------------------------------------------------------------------
package dpps_pkg;

   localparam int SLOTS      = 64;
   localparam int COUNT_BITS = 32;
   localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DIV_BITS   = COUNT_BITS + 4;

   localparam logic [2:0] OP_CREATE    = 3'd0;
   localparam logic [2:0] OP_SET_STATE = 3'd1;
   localparam logic [2:0] OP_TICK      = 3'd2;
   localparam logic [2:0] OP_PICK      = 3'd3;
   localparam logic [2:0] OP_DONE      = 3'd4;

   localparam logic [1:0] ST_UNUSED   = 2'd0;
   localparam logic [1:0] ST_SLEEPING = 2'd1;
   localparam logic [1:0] ST_RUNNABLE = 2'd2;
   localparam logic [1:0] ST_RUNNING  = 2'd3;

   localparam logic [6:0] PRIO_MAX     = 7'd100;
   localparam logic [3:0] NICE_DEFAULT = 4'd5;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_PASS1,
      FSM_DECIDE,
      FSM_DIVIDE,
      FSM_PASS2,
      FSM_REPLY
   } fsm_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]  id;
      logic [1:0]            state;
      logic [6:0]            base;
      logic [3:0]            nice;
      logic [COUNT_BITS-1:0] picks;
      logic [COUNT_BITS-1:0] created;
      logic [COUNT_BITS-1:0] runs;
      logic [COUNT_BITS-1:0] sleeps;
   } rec_type;

   typedef struct packed {
      logic [2:0]  op;
      logic        second;
      logic [5:0]  slot;
      logic [1:0]  new_state;
      logic [6:0]  static_prio;
      logic [31:0] start;
      logic [3:0]  nice_new;
   } ctl_type;

   typedef struct packed {
      logic                  found;
      logic [SLOT_BITS-1:0]  id;
      logic [6:0]            prio;
      logic [COUNT_BITS-1:0] picks;
      logic [COUNT_BITS-1:0] created;
      logic [3:0]            nice;
   } best_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (&v) ? v : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [6:0] dyn_prio(input logic [6:0] base, input logic [3:0] nice);
      logic signed [8:0] d;
      d = $signed({2'b00, base}) - $signed({5'b00000, nice}) + 9'sd5;
      if (d < 9'sd0) return 7'd0;
      if (d > 9'sd100) return PRIO_MAX;
      return d[6:0];
   endfunction

endpackage

### rtl/dpps_req_if.sv
// -----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one scheduler event per transaction.
// -----------------------------------------------------------------------------
interface dpps_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [5:0]  slot;
   logic [6:0]  static_priority;
   logic [31:0] start_time;
   logic [1:0]  new_state;

   modport source (output valid, operation, slot, static_priority, start_time, new_state,
                   input ready);
   modport sink (input valid, operation, slot, static_priority, start_time, new_state,
                 output ready);
endinterface

### rtl/dpps_rsp_if.sv
// -----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one scheduler result per transaction.
// -----------------------------------------------------------------------------
interface dpps_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] picked_slot;
   logic       picked_valid;
   logic [6:0] picked_priority;
   logic [3:0] slot_niceness;

   modport source (output valid, picked_slot, picked_valid, picked_priority, slot_niceness,
                   input ready);
   modport sink (input valid, picked_slot, picked_valid, picked_priority, slot_niceness,
                 output ready);
endinterface

### rtl/dpps_cell.sv
// -----------------------------------------------------------------------------
// Slot cell
// Holds one task record of the rotating ring and takes its neighbor's record
// on every shift.
// -----------------------------------------------------------------------------
module dpps_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [dpps_pkg::SLOT_BITS-1:0]      reset_id,
   input  logic                                shift,
   input  dpps_pkg::rec_type                   rec_in,
   output dpps_pkg::rec_type                   rec_out
);

   dpps_pkg::rec_type rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.id    <= reset_id;
         rec_ff.state <= dpps_pkg::ST_UNUSED;
      end else if (shift) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_out = rec_ff;

endmodule

### rtl/dpps_head.sv
// -----------------------------------------------------------------------------
// Ring head
// Updates the record leaving the head of the ring and rates it as a pick
// candidate against the best one seen so far.
// -----------------------------------------------------------------------------
module dpps_head (
   input  dpps_pkg::rec_type  head_rec,
   input  dpps_pkg::ctl_type  ctl,
   input  dpps_pkg::best_type best,
   output dpps_pkg::rec_type  tail_rec,
   output logic               hit,
   output logic               better,
   output logic [6:0]         prio
);

   always_comb begin
      hit  = (int'(head_rec.id) == int'(ctl.slot));
      prio = dpps_pkg::dyn_prio(head_rec.base, head_rec.nice);
      better = (head_rec.state == dpps_pkg::ST_RUNNABLE) &&
               (!best.found || (prio < best.prio) ||
                ((prio == best.prio) && ((head_rec.picks < best.picks) ||
                 ((head_rec.picks == best.picks) && (head_rec.created < best.created)))));

      tail_rec = head_rec;
      case (ctl.op)
         dpps_pkg::OP_CREATE: begin
            if (hit) begin
               tail_rec.state   = ctl.new_state;
               tail_rec.base    = (ctl.static_prio > dpps_pkg::PRIO_MAX) ?
                                  dpps_pkg::PRIO_MAX : ctl.static_prio;
               tail_rec.nice    = dpps_pkg::NICE_DEFAULT;
               tail_rec.created = dpps_pkg::COUNT_BITS'(ctl.start);
               tail_rec.picks   = '0;
               tail_rec.runs    = '0;
               tail_rec.sleeps  = '0;
            end
         end
         dpps_pkg::OP_SET_STATE: begin
            if (hit) tail_rec.state = ctl.new_state;
         end
         dpps_pkg::OP_TICK: begin
            if (head_rec.state == dpps_pkg::ST_SLEEPING)
               tail_rec.sleeps = dpps_pkg::sat_inc(head_rec.sleeps);
            else if (head_rec.state == dpps_pkg::ST_RUNNING)
               tail_rec.runs = dpps_pkg::sat_inc(head_rec.runs);
         end
         dpps_pkg::OP_PICK: begin
            if (ctl.second && (head_rec.id == best.id)) begin
               tail_rec.state = dpps_pkg::ST_RUNNING;
               tail_rec.picks = dpps_pkg::sat_inc(head_rec.picks);
            end
         end
         dpps_pkg::OP_DONE: begin
            if (hit) begin
               if (ctl.second) tail_rec.nice = ctl.nice_new;
               else tail_rec.state = ctl.new_state;
            end
         end
         default: ;
      endcase
   end

endmodule

### rtl/dpps_div.sv
// -----------------------------------------------------------------------------
// Niceness divider
// Computes floor(10*sleep/(sleep+run)) by four restoring steps, one
// quotient bit per cycle.
// -----------------------------------------------------------------------------
module dpps_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dpps_pkg::COUNT_BITS-1:0] sleeps,
   input  logic [dpps_pkg::COUNT_BITS-1:0] runs,
   output logic                            done,
   output logic [3:0]                      quotient
);

   localparam int W = dpps_pkg::DIV_BITS;

   logic [W-1:0] num_ff, num_in;
   logic [W-1:0] den_ff, den_in;
   logic [3:0]   q_ff, q_in;
   logic [2:0]   step_ff, step_in;
   logic         done_ff, done_in;
   logic [dpps_pkg::COUNT_BITS:0] sum;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      step_in = step_ff;
      done_in = 1'b0;
      sum     = {1'b0, sleeps} + {1'b0, runs};
      if (start) begin
         num_in  = (W'(sleeps) << 3) + (W'(sleeps) << 1);
         den_in  = {sum, 3'b000};
         q_in    = '0;
         step_in = 3'd4;
      end else if (step_ff != 3'd0) begin
         // Divisor starts at eight times the sum and halves each step.
         if (num_ff >= den_ff) begin
            num_in = num_ff - den_ff;
            q_in   = {q_ff[2:0], 1'b1};
         end else begin
            q_in   = {q_ff[2:0], 1'b0};
         end
         den_in  = den_ff >> 1;
         step_in = step_ff - 3'd1;
         done_in = (step_ff == 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

### rtl/dynamic_priority_process_selector.sv
// -----------------------------------------------------------------------------
// Dynamic priority process selector
// Task slot table with niceness-adjusted priority pick.
// -----------------------------------------------------------------------------
// The slot records sit in a ring of cells that rotates one place per cycle
// during each pass, so every record passes the head update logic once per
// pass. Create, set state and tick take one pass. Pick takes a search pass
// and an update pass. Done takes two passes plus the four-step divider
// between them. A pick that finds no runnable task and a done on a task
// with no run or sleep history end after the first pass. Events with an
// unknown code or an out-of-range slot answer without any pass. One event
// is worked on at a time; the next is taken as soon as the previous result
// sits in the output register.
// -----------------------------------------------------------------------------
module dynamic_priority_process_selector (
   input logic         clock,
   input logic         reset,
   dpps_req_if.sink    req_chan,
   dpps_rsp_if.source  rsp_chan
);

   localparam int N  = dpps_pkg::SLOTS;
   localparam int SB = dpps_pkg::SLOT_BITS;

   dpps_pkg::fsm_type  state_ff, state_in;
   logic [SB-1:0]      count_ff, count_in;
   dpps_pkg::ctl_type  ctl_ff, ctl_in;
   dpps_pkg::best_type best_ff, best_in;
   logic               zero_ff, zero_in;
   logic [3:0]         nice_ff, nice_in;
   logic [dpps_pkg::COUNT_BITS-1:0] cap_s_ff, cap_s_in, cap_r_ff, cap_r_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [5:0] rsp_slot_ff, rsp_slot_in;
   logic       rsp_pv_ff, rsp_pv_in;
   logic [6:0] rsp_prio_ff, rsp_prio_in;
   logic [3:0] rsp_nice_ff, rsp_nice_in;

   logic shift;
   logic div_start, div_done;
   logic [3:0] div_q;
   logic hit, better, addressed;
   logic [6:0] head_prio;

   dpps_pkg::rec_type ring [N];
   dpps_pkg::rec_type tail_rec;

   for (genvar i = 0; i < N; i++) begin : g_cell
      dpps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .reset_id (SB'(i)),
         .shift    (shift),
         .rec_in   ((i == N - 1) ? tail_rec : ring[(i + 1) % N]),
         .rec_out  (ring[i])
      );
   end

   dpps_head u_head (
      .head_rec (ring[0]),
      .ctl      (ctl_ff),
      .best     (best_ff),
      .tail_rec (tail_rec),
      .hit      (hit),
      .better   (better),
      .prio     (head_prio)
   );

   dpps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sleeps   (cap_s_ff),
      .runs     (cap_r_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign addressed = (ctl_ff.op == dpps_pkg::OP_CREATE) ||
                      (ctl_ff.op == dpps_pkg::OP_SET_STATE) ||
                      (ctl_ff.op == dpps_pkg::OP_DONE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ctl_in       = ctl_ff;
      best_in      = best_ff;
      zero_in      = zero_ff;
      nice_in      = nice_ff;
      cap_s_in     = cap_s_ff;
      cap_r_in     = cap_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_pv_in    = rsp_pv_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_nice_in  = rsp_nice_ff;
      shift        = 1'b0;
      div_start    = 1'b0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         dpps_pkg::FSM_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               ctl_in.op          = req_chan.operation;
               ctl_in.second      = 1'b0;
               ctl_in.slot        = req_chan.slot;
               ctl_in.new_state   = req_chan.new_state;
               ctl_in.static_prio = req_chan.static_priority;
               ctl_in.start       = req_chan.start_time;
               ctl_in.nice_new    = '0;
               best_in.found      = 1'b0;
               count_in           = '0;
               nice_in            = '0;
               zero_in            = 1'b0;
               if ((req_chan.operation > dpps_pkg::OP_DONE) ||
                   ((req_chan.operation != dpps_pkg::OP_TICK) &&
                    (req_chan.operation != dpps_pkg::OP_PICK) &&
                    (int'(req_chan.slot) >= N))) begin
                  zero_in  = 1'b1;
                  state_in = dpps_pkg::FSM_REPLY;
               end else begin
                  state_in = dpps_pkg::FSM_PASS1;
               end
            end
         end
         dpps_pkg::FSM_PASS1: begin
            shift = 1'b1;
            count_in = count_ff + SB'(1);
            if (addressed && hit) begin
               nice_in  = (ctl_ff.op == dpps_pkg::OP_CREATE) ?
                          dpps_pkg::NICE_DEFAULT : ring[0].nice;
               cap_s_in = ring[0].sleeps;
               cap_r_in = ring[0].runs;
            end
            if ((ctl_ff.op == dpps_pkg::OP_PICK) && better) begin
               best_in.found   = 1'b1;
               best_in.id      = ring[0].id;
               best_in.prio    = head_prio;
               best_in.picks   = ring[0].picks;
               best_in.created = ring[0].created;
               best_in.nice    = ring[0].nice;
            end
            if (int'(count_ff) == N - 1) begin
               count_in = '0;
               state_in = dpps_pkg::FSM_DECIDE;
            end
         end
         dpps_pkg::FSM_DECIDE: begin
            state_in = dpps_pkg::FSM_REPLY;
            if (ctl_ff.op == dpps_pkg::OP_PICK) begin
               if (best_ff.found) begin
                  ctl_in.second = 1'b1;
                  state_in      = dpps_pkg::FSM_PASS2;
               end else begin
                  zero_in = 1'b1;
               end
            end else if (ctl_ff.op == dpps_pkg::OP_DONE) begin
               // An empty history keeps the present niceness.
               if ((cap_s_ff != '0) || (cap_r_ff != '0)) begin
                  div_start = 1'b1;
                  state_in  = dpps_pkg::FSM_DIVIDE;
               end
            end else if (ctl_ff.op == dpps_pkg::OP_TICK) begin
               zero_in = 1'b1;
            end
         end
         dpps_pkg::FSM_DIVIDE: begin
            if (div_done) begin
               nice_in         = div_q;
               ctl_in.nice_new = div_q;
               ctl_in.second   = 1'b1;
               state_in        = dpps_pkg::FSM_PASS2;
            end
         end
         dpps_pkg::FSM_PASS2: begin
            shift = 1'b1;
            count_in = count_ff + SB'(1);
            if (int'(count_ff) == N - 1) begin
               count_in = '0;
               state_in = dpps_pkg::FSM_REPLY;
            end
         end
         dpps_pkg::FSM_REPLY: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               rsp_pv_in    = 1'b0;
               rsp_prio_in  = '0;
               rsp_nice_in  = '0;
               if (!zero_ff) begin
                  if (ctl_ff.op == dpps_pkg::OP_PICK) begin
                     rsp_slot_in = 6'(best_ff.id);
                     rsp_pv_in   = 1'b1;
                     rsp_prio_in = best_ff.prio;
                     rsp_nice_in = best_ff.nice;
                  end else begin
                     rsp_nice_in = nice_ff;
                  end
               end
               state_in = dpps_pkg::FSM_IDLE;
            end
         end
         default: state_in = dpps_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dpps_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ctl_ff      <= ctl_in;
      best_ff     <= best_in;
      zero_ff     <= zero_in;
      nice_ff     <= nice_in;
      cap_s_ff    <= cap_s_in;
      cap_r_ff    <= cap_r_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_prio_ff <= rsp_prio_in;
      rsp_nice_ff <= rsp_nice_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.picked_slot     = rsp_slot_ff;
   assign rsp_chan.picked_valid    = rsp_pv_ff;
   assign rsp_chan.picked_priority = rsp_prio_ff;
   assign rsp_chan.slot_niceness   = rsp_nice_ff;

endmodule

### rtl/dpps_checker.sv
// -----------------------------------------------------------------------------
// Scheduler checker
// Port-level checks on the scheduler's transactions and result values.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpps_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] picked_slot,
   input logic       picked_valid,
   input logic [6:0] picked_priority,
   input logic [3:0] slot_niceness
);

   // A failed or non-pick event reports no slot and no priority.
   `DPPS_NEVER(a_nopick_zero, clock, reset, rsp_valid && !picked_valid && ((picked_slot != 6'd0) || (picked_priority != 7'd0)))
   `DPPS_NEVER(a_prio_range, clock, reset, rsp_valid && (picked_priority > 7'd100))
   `DPPS_NEVER(a_nice_range, clock, reset, rsp_valid && (slot_niceness > 4'd10))
   // The block works on one transaction at a time.
   `DPPS_ASSERT(a_one_at_time, clock, reset, (req_valid && req_ready) |=> !req_ready)

endmodule

bind dynamic_priority_process_selector dpps_checker u_dpps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .picked_slot     (rsp_chan.picked_slot),
   .picked_valid    (rsp_chan.picked_valid),
   .picked_priority (rsp_chan.picked_priority),
   .slot_niceness   (rsp_chan.slot_niceness)
);

### sim/dynamic_priority_process_selector_tb.sv
// -----------------------------------------------------------------------------
// Dynamic priority process selector testbench
// Drives scheduler events through the request channel, predicts each result
// with a behavioral slot table and compares every response field by field.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dynamic_priority_process_selector_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int N_RANDOM       = 930;
   localparam int N_SLOTS        = dpps_pkg::SLOTS;
   localparam logic [2:0] OP_BAD_LO  = 3'd5;
   localparam logic [2:0] OP_BAD_MID = 3'd6;
   localparam logic [2:0] OP_BAD_HI  = 3'd7;

   typedef struct packed {
      logic [2:0]  operation;
      logic [5:0]  slot;
      logic [6:0]  static_priority;
      logic [31:0] start_time;
      logic [1:0]  new_state;
   } event_type;

   typedef struct packed {
      logic [5:0] picked_slot;
      logic       picked_valid;
      logic [6:0] picked_priority;
      logic [3:0] slot_niceness;
   } answer_type;

   typedef struct packed {
      event_type  ev;
      logic       has_answer;
      answer_type answer;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dpps_req_if req_chan ();
   dpps_rsp_if rsp_chan ();

   dynamic_priority_process_selector u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #1 clock = ~clock;

   // Shadow copy of the slot table.
   logic [1:0]  tbl_state   [N_SLOTS];
   logic [6:0]  tbl_base    [N_SLOTS];
   logic [3:0]  tbl_nice    [N_SLOTS];
   logic [31:0] tbl_picks   [N_SLOTS];
   logic [31:0] tbl_created [N_SLOTS];
   logic [31:0] tbl_runs    [N_SLOTS];
   logic [31:0] tbl_sleeps  [N_SLOTS];
   bit          tbl_written [N_SLOTS];

   answer_type  expected_answers [$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          idle_cycles   = 0;
   bit          failed        = 1'b0;

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

   function automatic logic [6:0] urgency(input int s);
      int d;
      d = int'(tbl_base[s]) - int'(tbl_nice[s]) + 5;
      if (d < 0) d = 0;
      if (d > 100) d = 100;
      return 7'(d);
   endfunction

   function automatic answer_type schedule_event(input event_type ev);
      answer_type a;
      int         best;
      logic [6:0] best_p;
      logic [6:0] p;
      logic [67:0] num_s, num_r;
      a = '0;
      best = -1;
      best_p = '0;
      case (ev.operation) inside
         dpps_pkg::OP_CREATE, dpps_pkg::OP_SET_STATE, dpps_pkg::OP_DONE: begin
            tbl_state[ev.slot] = ev.new_state;
            if (ev.operation == dpps_pkg::OP_CREATE) begin
               tbl_base[ev.slot]    = (ev.static_priority > dpps_pkg::PRIO_MAX) ?
                                      dpps_pkg::PRIO_MAX : ev.static_priority;
               tbl_nice[ev.slot]    = dpps_pkg::NICE_DEFAULT;
               tbl_created[ev.slot] = ev.start_time;
               tbl_picks[ev.slot]   = '0;
               tbl_runs[ev.slot]    = '0;
               tbl_sleeps[ev.slot]  = '0;
               tbl_written[ev.slot] = 1'b1;
            end else if (ev.operation == dpps_pkg::OP_DONE &&
                         (tbl_sleeps[ev.slot] != 0 || tbl_runs[ev.slot] != 0)) begin
               // Largest k with (10-k)*sleep >= k*run.
               tbl_nice[ev.slot] = 4'd0;
               for (int k = 10; k > 0; k--) begin
                  num_s = 68'(tbl_sleeps[ev.slot]) * 68'(10 - k);
                  num_r = 68'(tbl_runs[ev.slot]) * 68'(k);
                  if (num_s >= num_r) begin
                     tbl_nice[ev.slot] = 4'(k);
                     break;
                  end
               end
            end
            a.slot_niceness = tbl_nice[ev.slot];
         end
         dpps_pkg::OP_TICK: begin
            for (int i = 0; i < N_SLOTS; i++) begin
               if (tbl_state[i] == dpps_pkg::ST_SLEEPING)
                  tbl_sleeps[i] = bump(tbl_sleeps[i]);
               else if (tbl_state[i] == dpps_pkg::ST_RUNNING)
                  tbl_runs[i] = bump(tbl_runs[i]);
            end
         end
         dpps_pkg::OP_PICK: begin
            for (int i = 0; i < N_SLOTS; i++) begin
               if (tbl_state[i] != dpps_pkg::ST_RUNNABLE) continue;
               p = urgency(i);
               if (best < 0 || p < best_p ||
                   (p == best_p && (tbl_picks[i] < tbl_picks[best] ||
                    (tbl_picks[i] == tbl_picks[best] &&
                     tbl_created[i] < tbl_created[best])))) begin
                  best = i;
                  best_p = p;
               end
            end
            if (best >= 0) begin
               tbl_state[best] = dpps_pkg::ST_RUNNING;
               tbl_picks[best] = bump(tbl_picks[best]);
               a.picked_slot     = 6'(best);
               a.picked_valid    = 1'b1;
               a.picked_priority = best_p;
               a.slot_niceness   = tbl_nice[best];
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   // Sends one transaction with random leading gaps.
   task automatic send_event(input event_type ev);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_chan.valid           <= 1'b1;
      req_chan.operation       <= ev.operation;
      req_chan.slot            <= ev.slot;
      req_chan.static_priority <= ev.static_priority;
      req_chan.start_time      <= ev.start_time;
      req_chan.new_state       <= ev.new_state;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_row(input row_type r);
      answer_type a;
      // A slot that was never created holds undefined fields; create it first.
      if ((r.ev.operation == dpps_pkg::OP_SET_STATE || r.ev.operation == dpps_pkg::OP_DONE) &&
          !tbl_written[r.ev.slot])
         r.ev.operation = dpps_pkg::OP_CREATE;
      a = schedule_event(r.ev);
      if (r.has_answer && a != r.answer) begin
         $error("table row disagrees with predictor: expected %h got %h", r.answer, a);
         failed = 1'b1;
      end
      expected_answers.push_back(a);
      send_event(r.ev);
   endtask

   function automatic event_type random_event();
      event_type ev;
      int        sel;
      ev.slot            = 6'($urandom_range(N_SLOTS - 1));
      ev.static_priority = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(100));
      ev.start_time      = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(40));
      ev.new_state       = 2'($urandom_range(3));
      sel = $urandom_range(99);
      if (sel < 15) ev.operation = dpps_pkg::OP_CREATE;
      else if (sel < 30) ev.operation = dpps_pkg::OP_SET_STATE;
      else if (sel < 55) ev.operation = dpps_pkg::OP_TICK;
      else if (sel < 78) ev.operation = dpps_pkg::OP_PICK;
      else if (sel < 96) ev.operation = dpps_pkg::OP_DONE;
      else ev.operation = 3'($urandom_range(OP_BAD_HI, OP_BAD_LO));
      return ev;
   endfunction

   // Directed rows: extremes, every operation and special cases.
   row_type directed [] = '{
      '{'{dpps_pkg::OP_PICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b1, '0},
      '{'{dpps_pkg::OP_TICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b1, '0},
      '{'{OP_BAD_LO, 6'd63, 7'd127, 32'hFFFF_FFFF, dpps_pkg::ST_RUNNING}, 1'b1, '0},
      '{'{OP_BAD_HI, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b1, '0},
      '{'{OP_BAD_MID, 6'd42, 7'd85, 32'h5555_5555, dpps_pkg::ST_RUNNABLE}, 1'b1, '0},
      '{'{dpps_pkg::OP_CREATE, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_RUNNABLE}, 1'b1,
        '{6'd0, 1'b0, 7'd0, 4'd5}},
      '{'{dpps_pkg::OP_CREATE, 6'd63, 7'd127, 32'hFFFF_FFFF, dpps_pkg::ST_RUNNABLE}, 1'b1,
        '{6'd0, 1'b0, 7'd0, 4'd5}},
      '{'{dpps_pkg::OP_CREATE, 6'd21, 7'd100, 32'hAAAA_AAAA, dpps_pkg::ST_SLEEPING}, 1'b1,
        '{6'd0, 1'b0, 7'd0, 4'd5}},
      '{'{dpps_pkg::OP_PICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b1,
        '{6'd0, 1'b1, 7'd0, 4'd5}},
      '{'{dpps_pkg::OP_PICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b1,
        '{6'd63, 1'b1, 7'd100, 4'd5}},
      '{'{dpps_pkg::OP_PICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b1, '0},
      '{'{dpps_pkg::OP_TICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b0, '0},
      '{'{dpps_pkg::OP_TICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b0, '0},
      '{'{dpps_pkg::OP_DONE, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_RUNNABLE}, 1'b1,
        '{6'd0, 1'b0, 7'd0, 4'd0}},
      '{'{dpps_pkg::OP_DONE, 6'd21, 7'd0, 32'd0, dpps_pkg::ST_RUNNABLE}, 1'b1,
        '{6'd0, 1'b0, 7'd0, 4'd10}},
      '{'{dpps_pkg::OP_CREATE, 6'd42, 7'd50, 32'd7, dpps_pkg::ST_RUNNABLE}, 1'b0, '0},
      '{'{dpps_pkg::OP_DONE, 6'd42, 7'd0, 32'd0, dpps_pkg::ST_RUNNABLE}, 1'b1,
        '{6'd0, 1'b0, 7'd0, 4'd5}},
      '{'{dpps_pkg::OP_SET_STATE, 6'd63, 7'd0, 32'd0, dpps_pkg::ST_RUNNABLE}, 1'b1,
        '{6'd0, 1'b0, 7'd0, 4'd5}},
      '{'{dpps_pkg::OP_PICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b0, '0},
      '{'{dpps_pkg::OP_PICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b0, '0},
      '{'{dpps_pkg::OP_PICK, 6'd0, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b0, '0},
      '{'{dpps_pkg::OP_SET_STATE, 6'd42, 7'd0, 32'd0, dpps_pkg::ST_UNUSED}, 1'b1,
        '{6'd0, 1'b0, 7'd0, 4'd5}}
   };

   // Response checker.
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.picked_slot, rsp_chan.picked_valid,
                 rsp_chan.picked_priority, rsp_chan.slot_niceness};
         if (expected_answers.size() == 0) begin
            $error("response transaction with nothing expected: %h", got);
            failed = 1'b1;
         end else begin
            want = expected_answers.pop_front();
            if (got.picked_slot != want.picked_slot) begin
               $error("picked_slot expected %0d actual %0d", want.picked_slot, got.picked_slot);
               failed = 1'b1;
            end
            if (got.picked_valid != want.picked_valid) begin
               $error("picked_valid expected %0d actual %0d",
                      want.picked_valid, got.picked_valid);
               failed = 1'b1;
            end
            if (got.picked_priority != want.picked_priority) begin
               $error("picked_priority expected %0d actual %0d",
                      want.picked_priority, got.picked_priority);
               failed = 1'b1;
            end
            if (got.slot_niceness != want.slot_niceness) begin
               $error("slot_niceness expected %0d actual %0d",
                      want.slot_niceness, got.slot_niceness);
               failed = 1'b1;
            end
         end
      end
   end

   // Receiver stalls.
   always @(posedge clock) begin
      rsp_chan.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      event_type ev;
      row_type   r;
      req_chan.valid           = 1'b0;
      req_chan.operation       = '0;
      req_chan.slot            = '0;
      req_chan.static_priority = '0;
      req_chan.start_time      = '0;
      req_chan.new_state       = '0;
      for (int i = 0; i < N_SLOTS; i++) begin
         tbl_state[i] = dpps_pkg::ST_UNUSED;
         tbl_base[i] = '0; tbl_nice[i] = '0; tbl_picks[i] = '0;
         tbl_created[i] = '0; tbl_runs[i] = '0; tbl_sleeps[i] = '0;
         tbl_written[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) run_row(directed[i]);

      // Hold the sender until every outstanding response has drained.
      while (expected_answers.size() != 0) @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 3) begin
            send_idle_pct = 58; recv_idle_pct = 30;
         end else if (n == 2 * N_RANDOM / 3) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end else if (n == 0) begin
            send_idle_pct = 30; recv_idle_pct = 58;
         end
         ev = random_event();
         r = '{ev, 1'b0, '0};
         run_row(r);
      end

      while (expected_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed && expected_answers.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
